// ===== src/tppg_pkg.sv =====
// ----------------------------------------------------------------------------
// tppg_pkg
// shared constants, codes and controller/datapath interface types for the
// touch pan / pinch gesture tracker
// ----------------------------------------------------------------------------
package tppg_pkg;

  localparam int MAX_CONTACTS = 8;
  localparam int IDX_W        = $clog2(MAX_CONTACTS);
  localparam int CNT_W        = $clog2(MAX_CONTACTS + 1);
  localparam int SQRT_STEPS   = 17;
  localparam int STEP_W       = ($clog2(SQRT_STEPS) > IDX_W) ? $clog2(SQRT_STEPS) : IDX_W;

  localparam logic [11:0] THR_RESET = 12'd160;

  localparam logic [2:0] OP_DOWN       = 3'd0;
  localparam logic [2:0] OP_MOTION     = 3'd1;
  localparam logic [2:0] OP_UP         = 3'd2;
  localparam logic [2:0] OP_CANCEL     = 3'd3;
  localparam logic [2:0] OP_CANCEL_ALL = 3'd4;

  localparam logic [1:0] OWN_IGNORED = 2'd0;
  localparam logic [1:0] OWN_CAMERA  = 2'd1;
  localparam logic [1:0] OWN_CONTROL = 2'd2;

  localparam logic [1:0] ACT_PAN_START = 2'd0;
  localparam logic [1:0] ACT_PAN       = 2'd1;
  localparam logic [1:0] ACT_PAIR      = 2'd2;
  localparam logic [1:0] ACT_CONTROL   = 2'd3;

  typedef enum logic [1:0] {
    PLAN_DONE = 2'd0,
    PLAN_SLOP = 2'd1,
    PLAN_PAIR = 2'd2
  } plan_t;

  typedef enum logic [1:0] {
    MUL_X = 2'd0,
    MUL_Y = 2'd1,
    MUL_T = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [3:0]         ctl;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [16:0]        s0;
    logic [16:0]        s1;
    logic               last;
  } result_t;

  typedef struct packed {
    logic             accept;
    logic             scan1;
    logic             scan2;
    logic [IDX_W-1:0] idx;
    logic             apply;
    logic             decide;
    logic             mul_en;
    mul_sel_t         mul_sel;
    logic             sum;
    logic             sqrt_init;
    logic             sqrt_step;
    logic             pfin;
    logic             emit;
  } cmd_t;

  typedef struct packed {
    logic  need_scan2;
    plan_t plan;
    logic  is_pair;
    logic  pending;
    logic  out_free;
  } status_t;

endpackage

// ===== src/tppg_ctrl.sv =====
// ----------------------------------------------------------------------------
// tppg_ctrl
// sequencer: table scans, update, arithmetic steps and result drain
// ----------------------------------------------------------------------------
module tppg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  tppg_pkg::status_t st,
  output tppg_pkg::cmd_t    cmd
);
  import tppg_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_SCAN1  = 12'b000000000010,
    S_APPLY  = 12'b000000000100,
    S_SCAN2  = 12'b000000001000,
    S_DECIDE = 12'b000000010000,
    S_MULX   = 12'b000000100000,
    S_MULY   = 12'b000001000000,
    S_MULT   = 12'b000010000000,
    S_SUM    = 12'b000100000000,
    S_SQRT   = 12'b001000000000,
    S_PFIN   = 12'b010000000000,
    S_EMIT   = 12'b100000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    in_tready   = 1'b0;
    cmd         = '0;
    cmd.idx     = cnt_r[IDX_W-1:0];
    cmd.mul_sel = MUL_X;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = S_SCAN1;
        end
      end
      S_SCAN1: begin
        cmd.scan1 = 1'b1;
        if (cnt_r == STEP_W'(MAX_CONTACTS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_APPLY;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        cnt_nxt   = '0;
        state_nxt = st.need_scan2 ? S_SCAN2 : S_EMIT;
      end
      S_SCAN2: begin
        cmd.scan2 = 1'b1;
        if (cnt_r == STEP_W'(MAX_CONTACTS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DECIDE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = (st.plan == PLAN_DONE) ? S_EMIT : S_MULX;
      end
      S_MULX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_X;
        state_nxt   = S_MULY;
      end
      S_MULY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_Y;
        state_nxt   = S_MULT;
      end
      S_MULT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_T;
        state_nxt   = S_SUM;
      end
      S_SUM: begin
        cmd.sum       = 1'b1;
        cmd.sqrt_init = st.is_pair;
        cnt_nxt       = '0;
        state_nxt     = st.is_pair ? S_SQRT : S_EMIT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == STEP_W'(SQRT_STEPS - 1)) begin
          state_nxt = S_PFIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_PFIN: begin
        cmd.pfin  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (st.pending) begin
          cmd.emit = st.out_free;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/tppg_dp.sv =====
// ----------------------------------------------------------------------------
// tppg_dp
// datapath: contact table, gesture state, shared squarer, bitwise square
// root, result queue and output register
// ----------------------------------------------------------------------------
module tppg_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  tppg_pkg::cmd_t    cmd,
  output tppg_pkg::status_t st,
  input  logic [47:0]       in_tdata,
  input  logic [2:0]        in_tuser,
  input  logic              cfg_we,
  input  logic [11:0]       cfg_wdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [71:0]       out_tdata,
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);
  import tppg_pkg::*;

  function automatic result_t mk_res(logic [1:0] act, logic [3:0] c,
                                     logic signed [16:0] dx, logic signed [16:0] dy,
                                     logic [16:0] s0, logic [16:0] s1, logic lst);
    result_t r;
    r.action = act;
    r.ctl    = c;
    r.dx     = dx;
    r.dy     = dy;
    r.s0     = s0;
    r.s1     = s1;
    r.last   = lst;
    return r;
  endfunction

  // latched item
  logic [2:0]         op_r;
  logic [7:0]         fid_r;
  logic signed [15:0] px_r, py_r;
  logic               ins_r;
  logic [3:0]         hit_r;

  // contact table
  logic               tv_r [MAX_CONTACTS];
  logic [7:0]         tf_r [MAX_CONTACTS];
  logic signed [15:0] tx_r [MAX_CONTACTS];
  logic signed [15:0] ty_r [MAX_CONTACTS];
  logic [1:0]         to_r [MAX_CONTACTS];

  // scan results
  logic               fnd_r, fre_r;
  logic [IDX_W-1:0]   fnd_idx_r, fre_idx_r;
  logic [1:0]         fnd_own_r;
  logic [1:0]         cam_n_r;
  logic signed [15:0] ax_r, ay_r, bx_r, by_r;

  // gesture state
  logic [11:0]        thr_r;
  logic               arm_v_r;
  logic [7:0]         arm_f_r;
  logic [3:0]         arm_c_r;
  logic [CNT_W-1:0]   ctl_cnt_r, ctl_cnt_nxt;
  logic signed [15:0] base_x_r, base_y_r, prev_x_r, prev_y_r;
  logic               pan_r;
  logic signed [15:0] pcx_r, pcy_r;
  logic [16:0]        pspan_r;
  logic               bv_r;
  logic               kind_mv_r;
  plan_t              plan_r, plan_now;

  // arithmetic
  logic signed [16:0] dx_r, dy_r;
  logic signed [15:0] gx_r, gy_r;
  logic signed [16:0] mul_a;
  logic signed [33:0] prod;
  logic [32:0]        sqx_r, sqy_r;
  logic [23:0]        t2_r;
  logic [33:0]        d2;
  logic [33:0]        sv_r, sr_r, sb_r, trial;

  // results
  result_t            res_r [2];
  logic [1:0]         res_n_r, res_rd_r;
  result_t            out_r;

  // entry under the scan pointer
  logic               e_v;
  logic [7:0]         e_f;
  logic signed [15:0] e_x, e_y;
  logic [1:0]         e_o;

  // update decode
  logic               down_ok, move_ok, rem_ok, rebase, move_go;
  logic [1:0]         new_own;
  logic               down_ctl, rem_ctl, armed_match, activate;
  logic [IDX_W-1:0]   wr_idx;
  logic signed [16:0] sum_x, sum_y;

  assign e_v = tv_r[cmd.idx];
  assign e_f = tf_r[cmd.idx];
  assign e_x = tx_r[cmd.idx];
  assign e_y = ty_r[cmd.idx];
  assign e_o = to_r[cmd.idx];

  assign down_ok     = (op_r == OP_DOWN) && !fnd_r && fre_r;
  assign move_ok     = (op_r == OP_MOTION) && fnd_r;
  assign rem_ok      = ((op_r == OP_UP) || (op_r == OP_CANCEL)) && fnd_r;
  assign new_own     = !ins_r ? OWN_IGNORED : ((hit_r != 4'd0) ? OWN_CONTROL : OWN_CAMERA);
  assign down_ctl    = down_ok && (new_own == OWN_CONTROL);
  assign rem_ctl     = rem_ok && (fnd_own_r == OWN_CONTROL);
  assign armed_match = arm_v_r && (arm_f_r == fid_r);
  assign activate    = rem_ctl && (op_r == OP_UP) && armed_match && (hit_r == arm_c_r);
  assign rebase      = down_ok || rem_ok;
  assign move_go     = move_ok && (fnd_own_r == OWN_CAMERA) && (ctl_cnt_r == '0);
  assign wr_idx      = down_ok ? fre_idx_r : fnd_idx_r;

  always_comb begin
    if (down_ctl) begin
      ctl_cnt_nxt = ctl_cnt_r + 1'b1;
    end else if (rem_ctl && (ctl_cnt_r != '0)) begin
      ctl_cnt_nxt = ctl_cnt_r - 1'b1;
    end else begin
      ctl_cnt_nxt = ctl_cnt_r;
    end
  end

  always_comb begin
    plan_now = PLAN_DONE;
    if (cam_n_r == 2'd2) begin
      plan_now = PLAN_PAIR;
    end else if ((cam_n_r == 2'd1) && kind_mv_r && !pan_r) begin
      plan_now = PLAN_SLOP;
    end
  end

  assign sum_x = 17'(ax_r) + 17'(bx_r);
  assign sum_y = 17'(ay_r) + 17'(by_r);

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_X:   mul_a = dx_r;
      MUL_Y:   mul_a = dy_r;
      MUL_T:   mul_a = $signed({5'd0, thr_r});
      default: mul_a = '0;
    endcase
  end
  assign prod  = mul_a * mul_a;
  assign d2    = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign trial = sr_r + sb_r;

  assign st.need_scan2 = (rebase && (ctl_cnt_nxt == '0)) || move_go;
  assign st.plan       = plan_now;
  assign st.is_pair    = (plan_r == PLAN_PAIR);
  assign st.pending    = (res_rd_r != res_n_r);
  assign st.out_free   = !out_tvalid || out_tready;

  assign out_tdata = {out_r.s1, out_r.s0, out_r.dy, out_r.dx, out_r.ctl};
  assign out_tuser = out_r.action;
  assign out_tlast = out_r.last;

  // item, table payload, arithmetic and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_tuser;
      fid_r <= in_tdata[7:0];
      px_r  <= $signed(in_tdata[23:8]);
      py_r  <= $signed(in_tdata[39:24]);
      ins_r <= in_tdata[40];
      hit_r <= in_tdata[44:41];
    end
    if (cmd.apply && (down_ok || move_ok)) begin
      tx_r[wr_idx] <= px_r;
      ty_r[wr_idx] <= py_r;
      if (down_ok) begin
        tf_r[wr_idx] <= fid_r;
        to_r[wr_idx] <= new_own;
      end
    end
    if (cmd.scan1) begin
      if (!fnd_r && e_v && (e_f == fid_r)) begin
        fnd_idx_r <= cmd.idx;
        fnd_own_r <= e_o;
      end
      if (!fre_r && !e_v) begin
        fre_idx_r <= cmd.idx;
      end
    end
    if (cmd.scan2 && e_v && (e_o == OWN_CAMERA)) begin
      if (cam_n_r == 2'd0) begin
        ax_r <= e_x;
        ay_r <= e_y;
      end else if (cam_n_r == 2'd1) begin
        bx_r <= e_x;
        by_r <= e_y;
      end
    end
    if (cmd.decide) begin
      if (plan_now == PLAN_PAIR) begin
        dx_r <= 17'(bx_r) - 17'(ax_r);
        dy_r <= 17'(by_r) - 17'(ay_r);
        gx_r <= sum_x[16:1];
        gy_r <= sum_y[16:1];
      end else begin
        dx_r <= 17'(ax_r) - 17'(base_x_r);
        dy_r <= 17'(ay_r) - 17'(base_y_r);
      end
    end
    if (cmd.mul_en) begin
      unique case (cmd.mul_sel)
        MUL_X:   sqx_r <= prod[32:0];
        MUL_Y:   sqy_r <= prod[32:0];
        MUL_T:   t2_r  <= prod[23:0];
        default: t2_r  <= prod[23:0];
      endcase
    end
    if (cmd.sqrt_init) begin
      sv_r <= d2;
      sr_r <= '0;
      sb_r <= 34'd1 << 32;
    end else if (cmd.sqrt_step) begin
      if (sv_r >= trial) begin
        sv_r <= sv_r - trial;
        sr_r <= (sr_r >> 1) + sb_r;
      end else begin
        sr_r <= sr_r >> 1;
      end
      sb_r <= sb_r >> 2;
    end
    if (cmd.apply && activate) begin
      res_r[0] <= mk_res(ACT_CONTROL, arm_c_r, '0, '0, '0, '0, 1'b1);
    end
    if (cmd.decide && (cam_n_r == 2'd1) && kind_mv_r && pan_r) begin
      res_r[0] <= mk_res(ACT_PAN, 4'd0, 17'(ax_r) - 17'(prev_x_r),
                         17'(ay_r) - 17'(prev_y_r), '0, '0, 1'b1);
    end
    if (cmd.sum && (plan_r == PLAN_SLOP)) begin
      res_r[0] <= mk_res(ACT_PAN_START, 4'd0, '0, '0, '0, '0, 1'b0);
      res_r[1] <= mk_res(ACT_PAN, 4'd0, dx_r, dy_r, '0, '0, 1'b1);
    end
    if (cmd.pfin && kind_mv_r && bv_r) begin
      res_r[0] <= mk_res(ACT_PAIR, 4'd0, 17'(gx_r) - 17'(pcx_r),
                         17'(gy_r) - 17'(pcy_r), pspan_r, sr_r[16:0], 1'b1);
    end
    if (cmd.emit) begin
      out_r <= res_r[res_rd_r[0]];
    end
  end

  // control and gesture state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= THR_RESET;
      for (int i = 0; i < MAX_CONTACTS; i++) tv_r[i] <= 1'b0;
      fnd_r      <= 1'b0;
      fre_r      <= 1'b0;
      cam_n_r    <= '0;
      arm_v_r    <= 1'b0;
      arm_f_r    <= '0;
      arm_c_r    <= '0;
      ctl_cnt_r  <= '0;
      base_x_r   <= '0;
      base_y_r   <= '0;
      prev_x_r   <= '0;
      prev_y_r   <= '0;
      pan_r      <= 1'b0;
      pcx_r      <= '0;
      pcy_r      <= '0;
      pspan_r    <= '0;
      bv_r       <= 1'b0;
      kind_mv_r  <= 1'b0;
      plan_r     <= PLAN_DONE;
      res_n_r    <= '0;
      res_rd_r   <= '0;
      out_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (cmd.accept) begin
        fnd_r    <= 1'b0;
        fre_r    <= 1'b0;
        res_n_r  <= '0;
        res_rd_r <= '0;
      end
      if (cmd.scan1) begin
        if (!fnd_r && e_v && (e_f == fid_r)) fnd_r <= 1'b1;
        if (!fre_r && !e_v) fre_r <= 1'b1;
      end
      if (cmd.apply) begin
        cam_n_r   <= '0;
        kind_mv_r <= move_go;
        if (op_r == OP_CANCEL_ALL) begin
          for (int i = 0; i < MAX_CONTACTS; i++) tv_r[i] <= 1'b0;
          arm_v_r   <= 1'b0;
          arm_f_r   <= '0;
          arm_c_r   <= '0;
          ctl_cnt_r <= '0;
          base_x_r  <= '0;
          base_y_r  <= '0;
          prev_x_r  <= '0;
          prev_y_r  <= '0;
          pan_r     <= 1'b0;
          pcx_r     <= '0;
          pcy_r     <= '0;
          pspan_r   <= '0;
          bv_r      <= 1'b0;
        end else begin
          ctl_cnt_r <= ctl_cnt_nxt;
          if (down_ok) begin
            tv_r[wr_idx] <= 1'b1;
          end
          if (rem_ok) begin
            tv_r[wr_idx] <= 1'b0;
          end
          if (down_ctl && (ctl_cnt_r == '0)) begin
            arm_v_r <= 1'b1;
            arm_f_r <= fid_r;
            arm_c_r <= hit_r;
          end
          if (rem_ctl && armed_match) begin
            arm_v_r <= 1'b0;
            arm_f_r <= '0;
            arm_c_r <= '0;
          end
          if (rebase) begin
            pan_r <= 1'b0;
            bv_r  <= 1'b0;
          end
          if (activate) begin
            res_n_r <= 2'd1;
          end
        end
      end
      if (cmd.scan2 && e_v && (e_o == OWN_CAMERA) && (cam_n_r != 2'd3)) begin
        cam_n_r <= cam_n_r + 1'b1;
      end
      if (cmd.decide) begin
        plan_r <= plan_now;
        if (cam_n_r == 2'd1) begin
          if (!kind_mv_r) begin
            base_x_r <= ax_r;
            base_y_r <= ay_r;
          end
          prev_x_r <= ax_r;
          prev_y_r <= ay_r;
          if (kind_mv_r && pan_r) begin
            res_n_r <= 2'd1;
          end
        end else if ((cam_n_r == 2'd3) && kind_mv_r) begin
          pan_r <= 1'b0;
          bv_r  <= 1'b0;
        end
      end
      if (cmd.sum && (plan_r == PLAN_SLOP) && (d2 >= {10'd0, t2_r})) begin
        pan_r   <= 1'b1;
        res_n_r <= 2'd2;
      end
      if (cmd.pfin) begin
        pcx_r   <= gx_r;
        pcy_r   <= gy_r;
        pspan_r <= sr_r[16:0];
        bv_r    <= 1'b1;
        if (kind_mv_r && bv_r) begin
          res_n_r <= 2'd1;
        end
      end
      if (cmd.emit) begin
        out_tvalid <= 1'b1;
        res_rd_r   <= res_rd_r + 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/touch_pan_pinch_gesture_tracker.sv =====
// ----------------------------------------------------------------------------
// touch_pan_pinch_gesture_tracker
// turns touch events into control activations, pan and two-finger moves
// ----------------------------------------------------------------------------
// in channel: one touch event per item, opcode in in_tuser, finger, position,
// inside flag and hit control in in_tdata.
// out channel: zero to two result items per event, action in out_tuser,
// out_tlast marks the final result of an event.
// cfg: cfg_we writes the 12-bit pan slop threshold; the user must write it
// only while idle, as the block does not enforce this.
// sequence: every event takes a scan of the contact table and an update
// step; events that need camera geometry add a second scan, then for a slop
// check or a finger pair squaring on the shared multiplier and, for a finger
// pair, the bitwise square root. The next item is taken once every result
// of the current one has passed to the output register; the last may stay there.
// reset: contact table emptied, gesture state cleared, threshold set to 160.
// a stalled receiver holds the output register and the block waits before
// moving further results into it.
// ----------------------------------------------------------------------------
module touch_pan_pinch_gesture_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // finger_id, pos_x, pos_y, inside_present, hit_control
  input  logic [2:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // control_id, delta_x, delta_y, span_before, span_after
  output logic [1:0]  out_tuser,  // action
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata
);
  import tppg_pkg::*;

  cmd_t    cmd;
  status_t st;

  tppg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  tppg_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== src/tppg_chk.sv =====
// ----------------------------------------------------------------------------
// tppg_chk
// port-level checks for the gesture tracker
// ----------------------------------------------------------------------------
module tppg_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import tppg_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_ctl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ACT_CONTROL) |-> out_tlast && (out_tdata[71:4] == '0))
    else $error("control activation malformed");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ACT_PAN_START) |-> !out_tlast && (out_tdata == '0))
    else $error("pan start malformed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item taken while busy");

endmodule

bind touch_pan_pinch_gesture_tracker tppg_chk u_chk (.*);
